>>> sv/crcc_pkg.sv
// crcc_pkg: types, constants and bit-step functions of the crypto1 candidate check
// used by crypto1_candidate_state_check_top, no other dependencies
`default_nettype none

package crcc_pkg;

  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned StagesPerWord = 32 / StepsPerStage;
  localparam int unsigned BackStages    = 3 * StagesPerWord;
  localparam int unsigned NumStages     = 2 * BackStages;

  localparam logic [23:0] PolyOdd  = 24'h29CE5C;
  localparam logic [23:0] PolyEven = 24'h870804;
  localparam logic [31:0] FiltOut  = 32'hEC57E80A;
  localparam logic [31:0] FiltA    = 32'h000f22c0;
  localparam logic [31:0] FiltB    = 32'h0006c9c0;
  localparam logic [31:0] FiltC    = 32'h0003c8b0;
  localparam logic [31:0] FiltD    = 32'h0001e458;
  localparam logic [31:0] FiltE    = 32'h0000d938;

  localparam int unsigned NumCfg = 6;

  typedef enum logic [2:0] {
    CFG_RN0_ENC = 3'd0,
    CFG_UID_NT0 = 3'd1,
    CFG_UID_NT1 = 3'd2,
    CFG_RN1_ENC = 3'd3,
    CFG_NT1_SUC = 3'd4,
    CFG_AR1_ENC = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] od;
    logic [23:0] ev;
  } lfsr_t;

  typedef struct packed {
    lfsr_t       st;
    logic [31:0] ks;
  } fwd_t;

  function automatic logic filt(logic [23:0] x);
    logic [4:0]  f;
    logic [31:0] ta;
    logic [31:0] tb;
    logic [31:0] tc;
    logic [31:0] td;
    logic [31:0] te;
    ta = FiltA >> x[3:0];
    tb = FiltB >> x[7:4];
    tc = FiltC >> x[11:8];
    td = FiltD >> x[15:12];
    te = FiltE >> x[19:16];
    f  = {ta[4], tb[3], tc[2], td[1], te[0]};
    return FiltOut[f];
  endfunction

  // four steps backwards, word bits taken from nibble q counted from the high end, in reversed byte order
  function automatic lfsr_t back_quad(lfsr_t s, logic [31:0] w, logic fb, logic [2:0] q);
    lfsr_t      r;
    logic [4:0] idx;
    logic       par;
    r = s;
    for (int j = 0; j < StepsPerStage; j++) begin
      idx  = (5'd31 - {q, 2'b00} - 5'(j)) ^ 5'd24;
      par  = (filt(r.ev) & fb) ^ r.od[0] ^ w[idx]
           ^ (^(PolyEven & {1'b0, r.od[23:1]})) ^ (^(PolyOdd & r.ev));
      r    = '{od: r.ev, ev: {par, r.od[23:1]}};
    end
    return r;
  endfunction

  // four steps forward, keystream bits written into ks
  function automatic fwd_t fwd_quad(fwd_t s, logic [31:0] w, logic fb, logic [2:0] q);
    fwd_t       r;
    logic [4:0] idx;
    logic       ksb;
    logic       par;
    r = s;
    for (int j = 0; j < StepsPerStage; j++) begin
      idx        = ({q, 2'b00} + 5'(j)) ^ 5'd24;
      ksb        = filt(r.st.od);
      par        = (ksb & fb) ^ w[idx] ^ (^(PolyOdd & r.st.od)) ^ (^(PolyEven & r.st.ev));
      r.ks[idx]  = ksb;
      r.st       = '{od: {r.st.ev[22:0], par}, ev: r.st.od};
    end
    return r;
  endfunction

  // interleaved key bit order
  function automatic logic [47:0] key_of(lfsr_t s);
    logic [47:0] k;
    logic [4:0]  b;
    k = '0;
    for (int i = 0; i < 24; i++) begin
      b            = 5'(i) ^ 5'd3;
      k[2 * i + 1] = s.od[b];
      k[2 * i]     = s.ev[b];
    end
    return k;
  endfunction

endpackage

`default_nettype wire

>>> sv/crypto1_candidate_state_check_top.sv
// crypto1_candidate_state_check_top: pipelined check of one crypto1 candidate state per cycle
// depends on crcc_pkg for types, constants and the per-stage step functions
//
//  port group   | direction | contents
//  command      | in/out    | start_i, busy_o, odd_half_i, even_half_i
//  result       | out       | done_o, found_o, key_value_o
//  config       | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// a transaction enters on any cycle; its result appears after the lfsr stages and the compare stage, for one cycle
// 48 lfsr stages of four bit steps each (24 backwards, 24 forwards) and one compare stage
// busy_o stays low: the pipeline never stalls and the receiver cannot hold results off
// reset clears the valid bits and the config registers; payload is not reset
`default_nettype none

module crypto1_candidate_state_check_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [23:0] odd_half_i,
  input  wire logic [23:0] even_half_i,
  output logic             done_o,
  output logic             found_o,
  output logic [47:0]      key_value_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned NB = crcc_pkg::BackStages;
  localparam int unsigned NS = crcc_pkg::NumStages;

  logic [31:0] cfg_q [crcc_pkg::NumCfg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < crcc_pkg::NumCfg; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crcc_pkg::CFG_RN0_ENC: cfg_q[crcc_pkg::CFG_RN0_ENC] <= cfg_data_i;
        crcc_pkg::CFG_UID_NT0: cfg_q[crcc_pkg::CFG_UID_NT0] <= cfg_data_i;
        crcc_pkg::CFG_UID_NT1: cfg_q[crcc_pkg::CFG_UID_NT1] <= cfg_data_i;
        crcc_pkg::CFG_RN1_ENC: cfg_q[crcc_pkg::CFG_RN1_ENC] <= cfg_data_i;
        crcc_pkg::CFG_NT1_SUC: cfg_q[crcc_pkg::CFG_NT1_SUC] <= cfg_data_i;
        crcc_pkg::CFG_AR1_ENC: cfg_q[crcc_pkg::CFG_AR1_ENC] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic               vld_q [NS];
  logic               nz_q  [NS];
  crcc_pkg::lfsr_t    st_q  [NS];
  crcc_pkg::lfsr_t    key_q [NB:NS-1];
  logic [31:0]        ks_q  [NB:NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int unsigned Word = (s % NB) / crcc_pkg::StagesPerWord;
    localparam logic [2:0]  Qtr  = 3'(s % crcc_pkg::StagesPerWord);
    localparam logic        Fb   = (Word == 1);

    logic            vld_in;
    logic            nz_in;
    crcc_pkg::lfsr_t st_in;
    logic [31:0]     word;

    if (s == 0) begin : g_first
      assign vld_in = start_i;
      assign nz_in  = |{odd_half_i, even_half_i};
      assign st_in  = '{od: odd_half_i, ev: even_half_i};
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign nz_in  = nz_q[s-1];
      assign st_in  = st_q[s-1];
    end

    if (s < NB) begin : g_back
      if (Word == 0) begin : g_w0
        assign word = '0;
      end else if (Word == 1) begin : g_w1
        assign word = cfg_q[crcc_pkg::CFG_RN0_ENC];
      end else begin : g_w2
        assign word = cfg_q[crcc_pkg::CFG_UID_NT0];
      end

      always_ff @(posedge clk_i) begin
        st_q[s] <= crcc_pkg::back_quad(st_in, word, Fb, Qtr);
        nz_q[s] <= nz_in;
      end
    end else begin : g_fwd
      crcc_pkg::fwd_t  f_in;
      crcc_pkg::fwd_t  f_d;
      crcc_pkg::lfsr_t key_in;

      if (s == NB) begin : g_key
        assign key_in = st_in;
        assign f_in   = '{st: st_in, ks: '0};
      end else begin : g_carry
        assign key_in = key_q[s-1];
        assign f_in   = '{st: st_in, ks: ks_q[s-1]};
      end

      if (Word == 0) begin : g_w0
        assign word = cfg_q[crcc_pkg::CFG_UID_NT1];
      end else if (Word == 1) begin : g_w1
        assign word = cfg_q[crcc_pkg::CFG_RN1_ENC];
      end else begin : g_w2
        assign word = '0;
      end

      assign f_d = crcc_pkg::fwd_quad(f_in, word, Fb, Qtr);

      always_ff @(posedge clk_i) begin
        st_q[s]  <= f_d.st;
        ks_q[s]  <= f_d.ks;
        key_q[s] <= key_in;
        nz_q[s]  <= nz_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end
  end

  // compare stage
  logic        hit_d;
  logic        done_q;
  logic        found_q;
  logic [47:0] key_value_q;

  assign hit_d = nz_q[NS-1]
               && ((ks_q[NS-1] ^ cfg_q[crcc_pkg::CFG_NT1_SUC]) == cfg_q[crcc_pkg::CFG_AR1_ENC]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    found_q     <= hit_d;
    key_value_q <= hit_d ? crcc_pkg::key_of(key_q[NS-1]) : '0;
  end

  assign done_o      = done_q;
  assign found_o     = found_q;
  assign key_value_o = key_value_q;

endmodule

`default_nettype wire
